// ----- design/osb_pkg.sv -----
// Shared types and codes for the one-shot timer bank.
// Used by osb_alu, one_shot_timer_bank and osb_chk; depends on nothing.
package osb_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CREATE  = 2'd1;
    localparam logic [1:0] OP_DESTROY = 2'd2;
    localparam logic [1:0] OP_FIND    = 2'd3;

    localparam logic [1:0] MODE_TICKS   = 2'd1;
    localparam logic [1:0] MODE_SECONDS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ID    = 3'd1;
    localparam logic [2:0] ST_BAD_MODE  = 3'd2;
    localparam logic [2:0] ST_BAD_OWNER = 3'd3;
    localparam logic [2:0] ST_FIRED     = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;
    localparam logic [2:0] ST_NONE_FREE = 3'd6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  slot_id;
        logic [31:0] delay_amount;
        logic [1:0]  unit_mode;
        logic [15:0] owner_tag;
        logic        owner_ok;
        logic [31:0] now_seconds;
    } osb_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  result_slot;
        logic [15:0] fired_owner;
        logic        last;
    } osb_out_t;

    typedef struct packed {
        logic        secs;
        logic [32:0] count;
        logic [15:0] owner;
    } osb_entry_t;

    typedef struct packed {
        logic [32:0] a;
        logic [32:0] b;
        logic        sub;
    } osb_alu_req_t;

    typedef struct packed {
        logic [32:0] value;
        logic        le;
    } osb_alu_rsp_t;

endpackage

// ----- design/osb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module osb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/osb_alu.sv -----
// Shared 33-bit add/subtract unit with a less-or-equal flag.
// Depends on osb_pkg.
module osb_alu (
    input  osb_pkg::osb_alu_req_t req,
    output osb_pkg::osb_alu_rsp_t rsp
);
    import osb_pkg::*;

    logic [33:0] res;

    always_comb begin
        if (req.sub) begin
            res = {1'b0, req.a} - {1'b0, req.b};
        end else begin
            res = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.value = res[32:0];
        rsp.le    = res[33] || (res == 34'd0);
    end

endmodule

// ----- design/one_shot_timer_bank.sv -----
// Top level of the one-shot timer bank: sequencer, live-slot flags, output register.
// Depends on osb_pkg, osb_ram and osb_alu.
//
// A bank of SLOT_COUNT one-shot timers. Counts, deadlines and owners sit in one RAM with
// a registered read; a live flag per slot in flip-flops is cleared by reset. A tick
// transaction reads the first slot from the RAM, then walks the slots one per cycle
// (holding a slot while the result channel stalls its fired result) through a single
// 33-bit subtractor, which both decrements tick counts and compares deadlines with
// now_seconds, and ends with a done result. Create, destroy and find-free each end
// with one result, which likewise waits while the result channel stalls.
// s_ready is high only between transactions; the result register lets the next
// transaction start while the last result still waits on m_ready.
module one_shot_timer_bank #(
    parameter int SLOT_COUNT = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  osb_pkg::osb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output osb_pkg::osb_out_t m_data
);
    import osb_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
    localparam logic [7:0] SLOT_LIMIT = 8'(SLOT_COUNT);
    localparam int EW = $bits(osb_entry_t);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TICK   = 3'd1;
    localparam logic [2:0] S_CREATE = 3'd2;
    localparam logic [2:0] S_FIND   = 3'd3;
    localparam logic [2:0] S_RESP   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [SLOT_COUNT-1:0] alive_reg, alive_next;
    logic                  m_valid_reg, m_valid_next;
    osb_in_t               in_reg, in_next;
    osb_out_t              pend_reg, pend_next;
    osb_out_t              out_reg, out_next;

    logic          can_emit, s_accept, in_range_s, in_range_r, cur_alive;
    logic          tick_fire, tick_go, emit_valid;
    osb_out_t      emit_data;
    osb_entry_t    rd_entry, wr_entry;
    osb_alu_req_t  alu_req;
    osb_alu_rsp_t  alu_rsp;
    logic          ram_we, ram_re;
    logic [IW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    osb_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT)
    ) u_osb_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    osb_alu u_osb_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_ready    = (state_reg == S_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign can_emit   = !m_valid_reg || m_ready;
    assign in_range_s = (s_data.slot_id < SLOT_LIMIT);
    assign in_range_r = (in_reg.slot_id < SLOT_LIMIT);
    assign cur_alive  = alive_reg[idx_reg];
    assign rd_entry   = osb_entry_t'(ram_rdata);
    assign tick_fire  = cur_alive && alu_rsp.le;
    assign tick_go    = (state_reg == S_TICK) && (!tick_fire || can_emit);
    assign m_valid    = m_valid_reg;
    assign m_data     = out_reg;

    always_comb begin
        if (state_reg == S_CREATE) begin
            alu_req.a   = {1'b0, in_reg.now_seconds};
            alu_req.b   = {1'b0, in_reg.delay_amount};
            alu_req.sub = 1'b0;
        end else begin
            alu_req.a   = rd_entry.count;
            alu_req.b   = rd_entry.secs ? {1'b0, in_reg.now_seconds} : 33'd1;
            alu_req.sub = 1'b1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        alive_next   = alive_reg;
        in_next      = in_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg + IW'(1);
        wr_entry     = rd_entry;
        emit_valid   = 1'b0;
        emit_data    = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    in_next = s_data;
                    unique case (s_data.opcode)
                        OP_TICK: begin
                            idx_next   = '0;
                            ram_re     = 1'b1;
                            ram_raddr  = '0;
                            state_next = S_TICK;
                        end
                        OP_CREATE: begin
                            idx_next   = in_range_s ? s_data.slot_id[IW-1:0] : '0;
                            state_next = S_CREATE;
                        end
                        OP_DESTROY: begin
                            if (in_range_s) begin
                                alive_next[s_data.slot_id[IW-1:0]] = 1'b0;
                            end
                            pend_next.status      = in_range_s ? ST_OK : ST_BAD_ID;
                            pend_next.result_slot = '0;
                            pend_next.fired_owner = '0;
                            pend_next.last        = 1'b1;
                            state_next            = S_RESP;
                        end
                        OP_FIND: begin
                            idx_next   = '0;
                            state_next = S_FIND;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CREATE: begin
                pend_next.status      = ST_OK;
                pend_next.result_slot = '0;
                pend_next.fired_owner = '0;
                pend_next.last        = 1'b1;
                if (!in_range_r || cur_alive) begin
                    pend_next.status = ST_BAD_ID;
                end else if (in_reg.unit_mode != MODE_TICKS
                             && in_reg.unit_mode != MODE_SECONDS) begin
                    pend_next.status = ST_BAD_MODE;
                end else if (!in_reg.owner_ok) begin
                    pend_next.status = ST_BAD_OWNER;
                end else begin
                    alive_next[idx_reg] = 1'b1;
                    ram_we              = 1'b1;
                    wr_entry.secs       = (in_reg.unit_mode == MODE_SECONDS);
                    wr_entry.count      = (in_reg.unit_mode == MODE_SECONDS) ?
                                          alu_rsp.value : {1'b0, in_reg.delay_amount};
                    wr_entry.owner      = in_reg.owner_tag;
                end
                state_next = S_RESP;
            end
            S_FIND: begin
                pend_next.fired_owner = '0;
                pend_next.last        = 1'b1;
                if (!cur_alive) begin
                    pend_next.status      = ST_OK;
                    pend_next.result_slot = 6'(idx_reg);
                    state_next            = S_RESP;
                end else if (idx_reg == LAST_IDX) begin
                    pend_next.status      = ST_NONE_FREE;
                    pend_next.result_slot = '0;
                    state_next            = S_RESP;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_TICK: begin
                if (tick_go) begin
                    if (tick_fire) begin
                        alive_next[idx_reg]   = 1'b0;
                        emit_valid            = 1'b1;
                        emit_data.status      = ST_FIRED;
                        emit_data.result_slot = 6'(idx_reg);
                        emit_data.fired_owner = rd_entry.owner;
                        emit_data.last        = 1'b0;
                    end else if (cur_alive && !rd_entry.secs) begin
                        ram_we         = 1'b1;
                        wr_entry.count = alu_rsp.value;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_DONE;
                    end else begin
                        idx_next = idx_reg + IW'(1);
                        ram_re   = 1'b1;
                    end
                end
            end
            S_RESP: begin
                emit_valid = 1'b1;
                emit_data  = pend_reg;
                if (can_emit) begin
                    state_next = S_IDLE;
                end
            end
            S_DONE: begin
                emit_valid       = 1'b1;
                emit_data.status = ST_DONE;
                emit_data.last   = 1'b1;
                if (can_emit) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit_valid && can_emit) begin
            out_next     = emit_data;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            alive_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            alive_reg   <= alive_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg   <= in_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule

// ----- design/osb_chk.sv -----
// Port-level checker for the one-shot timer bank, bound to the top level.
// Depends on osb_pkg and one_shot_timer_bank.
module osb_chk (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input osb_pkg::osb_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input osb_pkg::osb_out_t m_data
);
    import osb_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    a_not_last_is_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.status == ST_FIRED)
        else $error("non-final result is not a fired result");

    a_done_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_DONE |->
            m_data.last && m_data.result_slot == 6'd0 && m_data.fired_owner == 16'd0)
        else $error("tick done result has stray fields");

    a_control_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_OK || m_data.status == ST_BAD_ID
            || m_data.status == ST_BAD_MODE || m_data.status == ST_BAD_OWNER
            || m_data.status == ST_NONE_FREE) |->
            m_data.last && m_data.fired_owner == 16'd0)
        else $error("control result has stray fields");

endmodule

bind one_shot_timer_bank osb_chk u_osb_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/tb_one_shot_timer_bank.sv -----
// Self-checking testbench for one_shot_timer_bank: directed table, then random traffic
// under four idle/stall phases, checked against an in-bench model of the timer bank.
// Depends on osb_pkg and the one_shot_timer_bank RTL.
module tb_one_shot_timer_bank;
    import osb_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int RANDOM_PER_PHASE = 118;
    localparam int MAX_PRINTS = 40;
    localparam logic [1:0] MODE_DEAD = 2'd0;
    localparam logic [1:0] MODE_RSVD = 2'd3;

    typedef struct {
        osb_in_t  item;
        bit       fixed;
        osb_out_t res;
    } row_t;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    osb_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    osb_out_t m_data;

    logic        row_fixed;
    osb_out_t    row_res;
    logic        in_fire;
    int          src_idle_pct;
    int          snk_stall_pct;
    int          err_count;
    int          queued_before;
    logic [31:0] now_cur;

    logic [1:0]  bank_mode [SLOT_COUNT];
    logic [32:0] bank_count[SLOT_COUNT];
    logic [15:0] bank_owner[SLOT_COUNT];
    osb_out_t    pending_results[$];
    row_t        dir_rows[$];

    one_shot_timer_bank #(
        .SLOT_COUNT(SLOT_COUNT)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic osb_out_t make_result(logic [2:0] st, logic [5:0] slot,
                                             logic [15:0] owner, logic last);
        osb_out_t r;
        r.status      = st;
        r.result_slot = slot;
        r.fired_owner = owner;
        r.last        = last;
        return r;
    endfunction

    function automatic osb_in_t make_item(logic [1:0] op, logic [7:0] id,
                                          logic [31:0] delay, logic [1:0] mode,
                                          logic [15:0] owner, logic ok, logic [31:0] now);
        osb_in_t t;
        t.opcode       = op;
        t.slot_id      = id;
        t.delay_amount = delay;
        t.unit_mode    = mode;
        t.owner_tag    = owner;
        t.owner_ok     = ok;
        t.now_seconds  = now;
        return t;
    endfunction

    // Advance the bank model by one transaction and queue the results it causes.
    function automatic void timer_bank_step(osb_in_t t);
        logic       fire;
        logic [2:0] st;
        int         free_idx;
        st = ST_OK;
        free_idx = 0;
        case (t.opcode)
            OP_TICK: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    fire = 1'b0;
                    if (bank_mode[i] == MODE_TICKS) begin
                        if (bank_count[i] <= 33'd1) fire = 1'b1;
                        else bank_count[i] = bank_count[i] - 33'd1;
                    end else if (bank_mode[i] == MODE_SECONDS) begin
                        if (bank_count[i] <= {1'b0, t.now_seconds}) fire = 1'b1;
                    end
                    if (fire) begin
                        bank_mode[i] = MODE_DEAD;
                        pending_results.push_back(
                            make_result(ST_FIRED, 6'(i), bank_owner[i], 1'b0));
                    end
                end
                pending_results.push_back(make_result(ST_DONE, '0, '0, 1'b1));
            end
            OP_CREATE: begin
                if (t.slot_id >= SLOT_COUNT) begin
                    st = ST_BAD_ID;
                end else if (bank_mode[t.slot_id] != MODE_DEAD) begin
                    st = ST_BAD_ID;
                end else if (t.unit_mode != MODE_TICKS && t.unit_mode != MODE_SECONDS) begin
                    st = ST_BAD_MODE;
                end else if (!t.owner_ok) begin
                    st = ST_BAD_OWNER;
                end else begin
                    bank_mode[t.slot_id]  = t.unit_mode;
                    bank_owner[t.slot_id] = t.owner_tag;
                    if (t.unit_mode == MODE_TICKS) begin
                        bank_count[t.slot_id] = {1'b0, t.delay_amount};
                    end else begin
                        bank_count[t.slot_id] = {1'b0, t.now_seconds} + {1'b0, t.delay_amount};
                    end
                end
                pending_results.push_back(make_result(st, '0, '0, 1'b1));
            end
            OP_DESTROY: begin
                if (t.slot_id >= SLOT_COUNT) st = ST_BAD_ID;
                else bank_mode[t.slot_id] = MODE_DEAD;
                pending_results.push_back(make_result(st, '0, '0, 1'b1));
            end
            default: begin
                st = ST_NONE_FREE;
                for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                    if (bank_mode[i] == MODE_DEAD) begin
                        st = ST_OK;
                        free_idx = i;
                    end
                end
                if (st == ST_OK) begin
                    pending_results.push_back(make_result(ST_OK, 6'(free_idx), '0, 1'b1));
                end else begin
                    pending_results.push_back(make_result(ST_NONE_FREE, '0, '0, 1'b1));
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
        if (err_count < MAX_PRINTS) begin
            $display("mismatch %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        end
        err_count++;
    endtask

    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, m_data);
                end else begin
                    row_res_check : begin
                        osb_out_t want;
                        want = pending_results.pop_front();
                        if (m_data.status !== want.status)
                            report_mismatch("status", want.status, m_data.status);
                        if (m_data.result_slot !== want.result_slot)
                            report_mismatch("result_slot", want.result_slot, m_data.result_slot);
                        if (m_data.fired_owner !== want.fired_owner)
                            report_mismatch("fired_owner", want.fired_owner, m_data.fired_owner);
                        if (m_data.last !== want.last)
                            report_mismatch("last", want.last, m_data.last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                queued_before = pending_results.size();
                timer_bank_step(s_data);
                if (row_fixed) begin
                    while (pending_results.size() > queued_before) void'(pending_results.pop_back());
                    pending_results.push_back(row_res);
                end
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Hold each transaction until accepted; called and returns at a falling edge.
    task automatic send_item(osb_in_t item, bit fixed, osb_out_t res);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_data    <= item;
        row_fixed <= fixed;
        row_res   <= res;
        do @(negedge aclk); while (!in_fire);
    endtask

    function automatic osb_in_t next_random_item(int k);
        osb_in_t t;
        int      r;
        bit      fill;
        fill = ((k / 30) % 3 == 2);
        t = make_item(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom,
                      2'($urandom_range(3)), 16'($urandom_range(65535)),
                      1'($urandom_range(1)), $urandom);
        r = $urandom_range(99);
        if (r < (fill ? 15 : 40)) begin
            t.opcode = OP_TICK;
            if ($urandom_range(99) < 3) now_cur = $urandom;
            else now_cur = now_cur + $urandom_range(5);
            t.now_seconds = now_cur;
        end else if (r < (fill ? 80 : 75)) begin
            t.opcode = OP_CREATE;
            if ($urandom_range(99) < 85) t.slot_id = 8'($urandom_range(SLOT_COUNT - 1));
            if ($urandom_range(99) < 85)
                t.unit_mode = $urandom_range(1) ? MODE_TICKS : MODE_SECONDS;
            if ($urandom_range(99) < 90) t.owner_ok = 1'b1;
            r = $urandom_range(99);
            if (fill) t.delay_amount = $urandom_range(200, 100000);
            else if (r < 80) t.delay_amount = $urandom_range(12);
            else if (r < 90) t.delay_amount = $urandom_range(1000);
            t.now_seconds = now_cur;
        end else if (r < (fill ? 88 : 87)) begin
            t.opcode = OP_DESTROY;
            if ($urandom_range(99) < 85) t.slot_id = 8'($urandom_range(SLOT_COUNT - 1));
        end else begin
            t.opcode = OP_FIND;
        end
        return t;
    endfunction

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        row_fixed     = 1'b0;
        row_res       = '0;
        in_fire       = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        err_count     = 0;
        now_cur       = 32'd1000;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            bank_mode[i]  = MODE_DEAD;
            bank_count[i] = '0;
            bank_owner[i] = '0;
        end

        dir_rows.push_back('{make_item(OP_TICK, 0, 0, MODE_DEAD, 0, 0, 0), 1,
                             make_result(ST_DONE, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_FIND, 0, 0, MODE_DEAD, 0, 0, 0), 1,
                             make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 16, 5, MODE_TICKS, 1, 1, 0), 1,
                             make_result(ST_BAD_ID, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 255, 5, MODE_TICKS, 1, 1, 0), 1,
                             make_result(ST_BAD_ID, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 0, 5, MODE_DEAD, 1, 1, 0), 1,
                             make_result(ST_BAD_MODE, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 0, 5, MODE_RSVD, 1, 1, 0), 1,
                             make_result(ST_BAD_MODE, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 0, 5, MODE_TICKS, 1, 0, 0), 1,
                             make_result(ST_BAD_OWNER, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 0, 0, MODE_TICKS, 16'hFFFF, 1, 0), 1,
                             make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 1, 1, MODE_TICKS, 16'h1234, 1, 0), 1,
                             make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 2, 2, MODE_TICKS, 0, 1, 0), 1,
                             make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 15, 32'hFFFF_FFFF, MODE_SECONDS, 16'hA5A5, 1,
                                       32'hFFFF_FFFF), 1, make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 3, 0, MODE_SECONDS, 16'h5A5A, 1, 100), 1,
                             make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 4, 32'hFFFF_FFFF, MODE_TICKS, 16'h0F0F, 1, 0),
                             1, make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 0, 7, MODE_TICKS, 1, 1, 0), 1,
                             make_result(ST_BAD_ID, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_FIND, 0, 0, MODE_DEAD, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_item(OP_TICK, 0, 0, MODE_DEAD, 0, 0, 100), 0, '0});
        dir_rows.push_back('{make_item(OP_TICK, 0, 0, MODE_DEAD, 0, 0, 32'hFFFF_FFFF), 0, '0});
        dir_rows.push_back('{make_item(OP_TICK, 0, 0, MODE_DEAD, 0, 0, 0), 0, '0});
        dir_rows.push_back('{make_item(OP_DESTROY, 15, 0, MODE_DEAD, 0, 0, 0), 1,
                             make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_DESTROY, 15, 0, MODE_DEAD, 0, 0, 0), 1,
                             make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_DESTROY, 64, 0, MODE_DEAD, 0, 0, 0), 1,
                             make_result(ST_BAD_ID, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_DESTROY, 255, 0, MODE_DEAD, 0, 0, 0), 1,
                             make_result(ST_BAD_ID, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_CREATE, 7, 5, MODE_SECONDS, 16'h8001, 1,
                                       32'hFFFF_FFFF), 1, make_result(ST_OK, 0, 0, 1)});
        dir_rows.push_back('{make_item(OP_TICK, 0, 0, MODE_DEAD, 0, 0, 32'hFFFF_FFFF), 0, '0});
        dir_rows.push_back('{make_item(OP_DESTROY, 4, 0, MODE_DEAD, 0, 0, 0), 1,
                             make_result(ST_OK, 0, 0, 1)});

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = (p == 1 || p == 3) ? ((p == 1) ? 83 : 11) : 0;
            snk_stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 83 : 11) : 0;
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                send_item(next_random_item(k), 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge aclk);
        repeat (2 * SLOT_COUNT + 8) @(negedge aclk);

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/osb_pkg.sv
design/osb_ram.sv
design/osb_alu.sv
design/one_shot_timer_bank.sv
design/osb_chk.sv
tb/tb_one_shot_timer_bank.sv
